@@ rtl/core/ssk_pkg.sv @@
// Package for the space-saving top-k counter.
// Shared widths, status codes, controller/datapath command and status structs.
// No dependencies.
package ssk_pkg;

  localparam int COUNTERS_DEF = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int MAX_RESULTS  = 16;
  localparam int KEY_W        = 32;
  localparam int CNT_W        = 32;

  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_FREE = 2'd1;
  localparam logic [1:0] ST_REPL = 2'd2;
  localparam logic [1:0] ST_DUMP = 2'd3;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_dump;
    logic wr_hit;
    logic wr_free;
    logic wr_repl;
    logic dump_emit;
    logic dump_last;
  } ssk_cmd_t;

  typedef struct packed {
    logic mode;
    logic hit;
    logic free;
    logic scan_done;
    logic out_free;
  } ssk_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

@@ rtl/core/ssk_ctrl.sv @@
// Controller for the space-saving top-k counter.
// Sequences match, minimum scan, replace and ranked dump; depends on ssk_pkg.
module ssk_ctrl #(
  parameter int COUNTERS = ssk_pkg::COUNTERS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ssk_pkg::ssk_stat_t stat_i,
  output ssk_pkg::ssk_cmd_t  cmd_o
);
  import ssk_pkg::*;

  localparam int NRES = (COUNTERS < MAX_RESULTS) ? COUNTERS : MAX_RESULTS;
  localparam int RW   = (NRES > 1) ? $clog2(NRES) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_MSCAN = 3'd2;
  localparam logic [2:0] S_REPL  = 3'd3;
  localparam logic [2:0] S_DSCAN = 3'd4;
  localparam logic [2:0] S_DEMIT = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [RW-1:0] rank_q, rank_d;
  logic          rank_last;

  assign rank_last  = (rank_q == RW'(NRES - 1));
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    rank_d  = rank_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MATCH;
        end
      end
      S_MATCH: begin
        if (stat_i.mode) begin
          cmd_o.scan_start = 1'b1;
          cmd_o.scan_dump  = 1'b1;
          rank_d           = '0;
          state_d          = S_DSCAN;
        end else if (stat_i.hit) begin
          if (stat_i.out_free) begin
            cmd_o.wr_hit = 1'b1;
            state_d      = S_IDLE;
          end
        end else if (stat_i.free) begin
          if (stat_i.out_free) begin
            cmd_o.wr_free = 1'b1;
            state_d       = S_IDLE;
          end
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_MSCAN;
        end
      end
      S_MSCAN: begin
        if (stat_i.scan_done) state_d = S_REPL;
      end
      S_REPL: begin
        if (stat_i.out_free) begin
          cmd_o.wr_repl = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_DSCAN: begin
        if (stat_i.scan_done) state_d = S_DEMIT;
      end
      S_DEMIT: begin
        if (stat_i.out_free) begin
          cmd_o.dump_emit = 1'b1;
          cmd_o.dump_last = rank_last;
          if (rank_last) begin
            state_d = S_IDLE;
          end else begin
            rank_d           = rank_q + 1'b1;
            cmd_o.scan_start = 1'b1;
            cmd_o.scan_dump  = 1'b1;
            state_d          = S_DSCAN;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rank_q  <= '0;
    end else begin
      state_q <= state_d;
      rank_q  <= rank_d;
    end
  end

endmodule

@@ rtl/core/ssk_dpath.sv @@
// Datapath for the space-saving top-k counter: entry table, parallel key match,
// one-entry-per-cycle count scan, output register. Depends on ssk_pkg.
module ssk_dpath #(
  parameter int COUNTERS = ssk_pkg::COUNTERS_DEF,
  parameter int KEY_BITS = ssk_pkg::KEY_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    mode_i,
  input  logic [ssk_pkg::KEY_W-1:0] key_i,
  input  ssk_pkg::ssk_cmd_t       cmd_i,
  output ssk_pkg::ssk_stat_t      stat_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              status_o,
  output logic [ssk_pkg::KEY_W-1:0] entry_key_o,
  output logic [ssk_pkg::CNT_W-1:0] entry_count_o,
  output logic [ssk_pkg::CNT_W-1:0] entry_error_o,
  output logic                    occupied_o,
  output logic                    last_o
);
  import ssk_pkg::*;

  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int IW = $clog2(COUNTERS);

  logic [KW-1:0]    keys_q   [COUNTERS];
  logic [CNT_W-1:0] counts_q [COUNTERS];
  logic [CNT_W-1:0] errors_q [COUNTERS];
  logic [COUNTERS-1:0] used_q;

  logic          mode_q;
  logic [KW-1:0] key_q;

  logic          hit, free;
  logic [IW-1:0] hit_idx, free_idx;

  // scan sequencer and compare stage
  logic          run_q, kind_q, first_q, done_q;
  logic [IW-1:0] idx_q;
  logic          p_vld_q;
  logic [IW-1:0] p_idx_q;
  logic [CNT_W-1:0] p_cnt_q;
  logic          best_vld_q;
  logic [IW-1:0] best_idx_q, prev_idx_q;
  logic [CNT_W-1:0] best_cnt_q, prev_cnt_q;
  logic          elig, take;

  logic          out_vld_q, out_free, out_ld;
  logic [IW-1:0] wr_idx;
  logic [CNT_W-1:0] inc_cnt;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free     = 1'b0;
    free_idx = '0;
    for (int i = COUNTERS - 1; i >= 0; i--) begin
      if (used_q[i] && keys_q[i] == key_q) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
      if (!used_q[i]) begin
        free     = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign elig = first_q || (p_cnt_q < prev_cnt_q) ||
                (p_cnt_q == prev_cnt_q && p_idx_q > prev_idx_q);
  assign take = kind_q ? (elig && (!best_vld_q || p_cnt_q > best_cnt_q))
                       : (!best_vld_q || p_cnt_q <= best_cnt_q);

  assign out_free = !out_vld_q || out_ready_i;
  assign out_ld   = cmd_i.wr_hit || cmd_i.wr_free || cmd_i.wr_repl || cmd_i.dump_emit;
  assign wr_idx   = cmd_i.wr_hit ? hit_idx : (cmd_i.wr_free ? free_idx : best_idx_q);
  assign inc_cnt  = sat_inc(cmd_i.wr_hit ? counts_q[hit_idx] : best_cnt_q);

  assign stat_o.mode      = mode_q;
  assign stat_o.hit       = hit;
  assign stat_o.free      = free;
  assign stat_o.scan_done = done_q;
  assign stat_o.out_free  = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      key_q  <= key_i[KW-1:0];
    end
    if (cmd_i.wr_free || cmd_i.wr_repl) keys_q[wr_idx] <= key_q;
    p_idx_q <= idx_q;
    p_cnt_q <= counts_q[idx_q];
    if (p_vld_q && take) begin
      best_idx_q <= p_idx_q;
      best_cnt_q <= p_cnt_q;
    end
    if (cmd_i.dump_emit) begin
      prev_idx_q <= best_idx_q;
      prev_cnt_q <= best_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      for (int i = 0; i < COUNTERS; i++) begin
        counts_q[i] <= '0;
        errors_q[i] <= '0;
      end
    end else if (cmd_i.wr_hit) begin
      counts_q[wr_idx] <= inc_cnt;
    end else if (cmd_i.wr_free) begin
      used_q[wr_idx]   <= 1'b1;
      counts_q[wr_idx] <= CNT_W'(1);
      errors_q[wr_idx] <= '0;
    end else if (cmd_i.wr_repl) begin
      counts_q[wr_idx] <= inc_cnt;
      errors_q[wr_idx] <= best_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      kind_q     <= 1'b0;
      first_q    <= 1'b0;
      done_q     <= 1'b0;
      idx_q      <= '0;
      p_vld_q    <= 1'b0;
      best_vld_q <= 1'b0;
    end else begin
      done_q  <= p_vld_q && (p_idx_q == IW'(COUNTERS - 1));
      p_vld_q <= run_q;
      if (p_vld_q && take) best_vld_q <= 1'b1;
      if (run_q) begin
        if (idx_q == IW'(COUNTERS - 1)) run_q <= 1'b0;
        else idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.load) first_q <= 1'b1;
      else if (cmd_i.dump_emit) first_q <= 1'b0;
      if (cmd_i.scan_start) begin
        run_q      <= 1'b1;
        kind_q     <= cmd_i.scan_dump;
        idx_q      <= '0;
        best_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_ld) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_hit) begin
      status_o      <= ST_HIT;
      entry_key_o   <= KEY_W'(keys_q[wr_idx]);
      entry_count_o <= inc_cnt;
      entry_error_o <= errors_q[wr_idx];
      occupied_o    <= 1'b1;
      last_o        <= 1'b1;
    end else if (cmd_i.wr_free) begin
      status_o      <= ST_FREE;
      entry_key_o   <= KEY_W'(key_q);
      entry_count_o <= CNT_W'(1);
      entry_error_o <= '0;
      occupied_o    <= 1'b1;
      last_o        <= 1'b1;
    end else if (cmd_i.wr_repl) begin
      status_o      <= ST_REPL;
      entry_key_o   <= KEY_W'(key_q);
      entry_count_o <= inc_cnt;
      entry_error_o <= best_cnt_q;
      occupied_o    <= 1'b1;
      last_o        <= 1'b1;
    end else if (cmd_i.dump_emit) begin
      status_o <= ST_DUMP;
      last_o   <= cmd_i.dump_last;
      if (used_q[best_idx_q]) begin
        entry_key_o   <= KEY_W'(keys_q[best_idx_q]);
        entry_count_o <= best_cnt_q;
        entry_error_o <= errors_q[best_idx_q];
        occupied_o    <= 1'b1;
      end else begin
        entry_key_o   <= '0;
        entry_count_o <= '0;
        entry_error_o <= '0;
        occupied_o    <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

@@ rtl/core/space_saving_top_k.sv @@
// Space-saving top-k frequent-item counter, top level.
// Joins ssk_ctrl and ssk_dpath; depends on ssk_pkg.
//
// Usage: input channel (in_valid_i/in_ready_o) carries mode_i and key_i. Mode 0
// counts one key and yields one result; mode 1 dumps the table, yielding
// min(COUNTERS,16) results in descending count order, the final one with last_o.
// Output channel (out_valid_o/out_ready_i) carries one result per transfer from
// an output register, so a new item is taken while a result waits.
// Flow: a hit or a free-entry placement is loaded in the idle state and written
// with its result from the match state. A replacement of the minimum adds a
// scan of the table at one entry per cycle through the count read port. In a
// dump each rank is found by a full count scan before it is emitted.
// Reset: all entries empty, counts and errors zero; no clearing pass is needed.
// Stall: while out_ready_i is low the held result stays; the block finishes at
// most up to the next result and then waits, accepting no further item until
// that result can be loaded.
module space_saving_top_k #(
  parameter int COUNTERS = ssk_pkg::COUNTERS_DEF,
  parameter int KEY_BITS = ssk_pkg::KEY_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic [ssk_pkg::KEY_W-1:0] key_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [ssk_pkg::KEY_W-1:0] entry_key_o,
  output logic [ssk_pkg::CNT_W-1:0] entry_count_o,
  output logic [ssk_pkg::CNT_W-1:0] entry_error_o,
  output logic                      occupied_o,
  output logic                      last_o
);
  import ssk_pkg::*;

  ssk_cmd_t  cmd;
  ssk_stat_t stat;

  ssk_ctrl #(
    .COUNTERS(COUNTERS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ssk_dpath #(
    .COUNTERS(COUNTERS),
    .KEY_BITS(KEY_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .entry_key_o  (entry_key_o),
    .entry_count_o(entry_count_o),
    .entry_error_o(entry_error_o),
    .occupied_o   (occupied_o),
    .last_o       (last_o)
  );

endmodule
